/* rtl/core/slth_pkg.sv */
// types, constants and helper functions shared by the summed lookup table heuristic
package slth_pkg;

  // sizes of the table store
  localparam int unsigned MaxTables = 16;
  localparam int unsigned MaxStates = 256;
  localparam int unsigned MaxAbs    = 64;

  localparam int unsigned TIdxW    = (MaxTables > 1) ? $clog2(MaxTables) : 1;
  localparam int unsigned UsedW    = $clog2(MaxTables + 1);
  localparam int unsigned StateW   = $clog2(MaxStates);
  localparam int unsigned AbsIdxW  = (MaxAbs > 1) ? $clog2(MaxAbs) : 1;
  localparam int unsigned EntAddrW = TIdxW + StateW;
  localparam int unsigned ClrW     = StateW + 1;

  // fixed payload widths
  localparam int unsigned AbsW  = 6;
  localparam int unsigned SlotW = 8;
  localparam int unsigned ValW  = 32;

  // infinity codes and the finite saturation limit
  localparam logic signed [ValW-1:0] PosInf  = 32'sh7FFF_FFFF;
  localparam logic signed [ValW-1:0] NegInf  = 32'sh8000_0001;
  localparam logic signed [ValW-1:0] MostNeg = 32'sh8000_0000;
  localparam logic signed [ValW-1:0] FinMax  = 32'sh7FFF_FFFE;
  localparam logic signed [ValW-1:0] FinMin  = 32'sh8000_0002;
  localparam logic signed [ValW:0]   SumMax  = 33'sh0_7FFF_FFFE;
  localparam logic signed [ValW:0]   SumMin  = -33'sh0_7FFF_FFFE;

  // item function codes
  localparam logic FuncAdd   = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StAddChk,
    StClear,
    StEvQid,
    StEvEnt,
    StEvAcc,
    StDone
  } slth_state_e;

  // one input beat
  typedef struct packed {
    logic                   func;
    logic [AbsW-1:0]        abstraction;
    logic [SlotW-1:0]       slot;
    logic signed [ValW-1:0] value;
    logic                   last;
  } slth_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic qid_wr;
    logic merge_wr;
    logic claim;
    logic set_full;
    logic clr_wr;
    logic ev_start;
    logic ev_qid_rd;
    logic ev_ent_rd;
    logic ev_acc;
    logic out_load;
  } slth_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic abs_ok;
    logic hit;
    logic val_zero;
    logic used_full;
    logic used_zero;
    logic clr_last;
    logic ev_stop;
    logic out_free;
  } slth_status_t;

  function automatic logic is_inf(logic signed [ValW-1:0] x);
    return (x == PosInf) || (x == NegInf);
  endfunction

  // finite add saturating short of infinity
  function automatic logic signed [ValW-1:0] sat_add(logic signed [ValW-1:0] a,
                                                     logic signed [ValW-1:0] b);
    logic signed [ValW:0] s;
    s = {a[ValW-1], a} + {b[ValW-1], b};
    if (s > SumMax) begin
      return FinMax;
    end else if (s < SumMin) begin
      return FinMin;
    end
    return s[ValW-1:0];
  endfunction

endpackage

/* rtl/core/slth_ifs.sv */
// valid/ready channel interfaces for items and results
interface slth_in_if;
  import slth_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [AbsW-1:0]        abstraction;
  logic [SlotW-1:0]       slot;
  logic signed [ValW-1:0] value;
  logic                   last;

  modport source (output valid, func, abstraction, slot, value, last, input ready);
  modport sink   (input valid, func, abstraction, slot, value, last, output ready);
endinterface

interface slth_out_if;
  import slth_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] estimate;
  logic                   store_full;

  modport source (output valid, estimate, store_full, input ready);
  modport sink   (input valid, estimate, store_full, output ready);
endinterface

/* rtl/core/slth_datapath.sv */
// table store, query id store, merge unit, evaluation accumulator and result register
module slth_datapath import slth_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  slth_item_t             item_i,
  input  slth_cmd_t              cmd_i,
  output slth_status_t           status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [ValW-1:0] out_estimate_o,
  output logic                   out_store_full_o
);

  // table tags and bookkeeping
  logic [AbsW-1:0]        tag_q [MaxTables];
  logic [UsedW-1:0]       used_q;
  logic                   full_q;

  // captured beat
  logic [AbsW-1:0]        abs_q;
  logic [StateW-1:0]      entry_q;
  logic signed [ValW-1:0] val_q;
  logic                   hit_q;
  logic [TIdxW-1:0]       tidx_q;

  // clear sweep
  logic [ClrW-1:0]        clr_q;

  // memories
  logic signed [ValW-1:0] ent_mem [MaxTables * MaxStates];
  logic [SlotW-1:0]       qid_mem [MaxAbs];
  logic signed [ValW-1:0] ent_rd_q;
  logic [SlotW-1:0]       qid_rd_q;

  // evaluation
  logic [TIdxW-1:0]       ev_i_q;
  logic signed [ValW-1:0] sum_q;
  logic signed [ValW-1:0] inf_val_q;
  logic                   inf_q;

  // result register
  logic                   out_valid_q;
  logic signed [ValW-1:0] est_q;
  logic                   out_full_q;

  logic                   hit_c;
  logic [TIdxW-1:0]       hit_idx_c;
  logic signed [ValW-1:0] val_norm;
  logic                   ent_we;
  logic [EntAddrW-1:0]    ent_waddr;
  logic signed [ValW-1:0] ent_wdata;
  logic [EntAddrW-1:0]    ent_raddr;
  logic signed [ValW-1:0] merged;
  logic signed [ValW-1:0] clr_data;
  logic signed [ValW-1:0] est_c;
  logic [AbsW-1:0]        ev_tag;

  // tag search over the claimed tables, lowest index first
  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    for (int t = 0; t < MaxTables; t++) begin
      if (!hit_c && (UsedW'(t) < used_q) && (tag_q[t] == item_i.abstraction)) begin
        hit_c     = 1'b1;
        hit_idx_c = TIdxW'(t);
      end
    end
  end

  // most negative input counts as minus infinity
  assign val_norm = (item_i.value == MostNeg) ? NegInf : item_i.value;

  // capture the beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      abs_q   <= item_i.abstraction;
      entry_q <= item_i.slot[StateW-1:0];
      val_q   <= val_norm;
      hit_q   <= hit_c;
    end
  end

  // table index: hit table on capture, new table on claim
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tidx_q <= hit_idx_c;
    end else if (cmd_i.claim) begin
      tidx_q <= used_q[TIdxW-1:0];
    end
  end

  // tags of claimed tables
  always_ff @(posedge clk_i) begin
    if (cmd_i.claim) begin
      tag_q[used_q[TIdxW-1:0]] <= abs_q;
    end
  end

  // table count and sticky full flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      full_q <= 1'b0;
    end else begin
      if (cmd_i.claim) begin
        used_q <= used_q + UsedW'(1);
      end
      if (cmd_i.set_full) begin
        full_q <= 1'b1;
      end
    end
  end

  // clear sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.claim) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + ClrW'(1);
    end
  end

  // left addition merge
  always_comb begin
    if (is_inf(ent_rd_q)) begin
      merged = ent_rd_q;
    end else if (is_inf(val_q)) begin
      merged = val_q;
    end else begin
      merged = sat_add(ent_rd_q, val_q);
    end
  end

  // a fresh table holds zero, so the new value lands as it is
  assign clr_data = (clr_q[StateW-1:0] == entry_q) ? val_q : '0;

  // entry store ports
  always_comb begin
    ent_we    = cmd_i.merge_wr || cmd_i.clr_wr;
    ent_waddr = cmd_i.clr_wr ? {tidx_q, clr_q[StateW-1:0]} : {tidx_q, entry_q};
    ent_wdata = cmd_i.clr_wr ? clr_data : merged;
    ent_raddr = cmd_i.ev_ent_rd ? {ev_i_q, qid_rd_q[StateW-1:0]}
                                : {hit_idx_c, item_i.slot[StateW-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (cmd_i.capture || cmd_i.ev_ent_rd) begin
      ent_rd_q <= ent_mem[ent_raddr];
    end
  end

  // query id store
  assign ev_tag = tag_q[ev_i_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.qid_wr) begin
      qid_mem[item_i.abstraction[AbsIdxW-1:0]] <= item_i.slot;
    end
    if (cmd_i.ev_qid_rd) begin
      qid_rd_q <= qid_mem[ev_tag[AbsIdxW-1:0]];
    end
  end

  // evaluation walk in claim order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_i_q <= '0;
      inf_q  <= 1'b0;
    end else if (cmd_i.ev_start) begin
      ev_i_q <= '0;
      inf_q  <= 1'b0;
    end else if (cmd_i.ev_acc) begin
      ev_i_q <= ev_i_q + TIdxW'(1);
      if (is_inf(ent_rd_q)) begin
        inf_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_start) begin
      sum_q <= '0;
    end else if (cmd_i.ev_acc) begin
      if (is_inf(ent_rd_q)) begin
        inf_val_q <= ent_rd_q;
      end else begin
        sum_q <= sat_add(sum_q, ent_rd_q);
      end
    end
  end

  // first infinity wins, else the sum clamped below at zero
  assign est_c = inf_q ? inf_val_q : (sum_q[ValW-1] ? '0 : sum_q);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      est_q      <= est_c;
      out_full_q <= full_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_estimate_o   = est_q;
  assign out_store_full_o = out_full_q;

  // status towards the controller
  always_comb begin
    status_o.abs_ok    = (32'(item_i.abstraction) < MaxAbs);
    status_o.hit       = hit_q;
    status_o.val_zero  = (val_q == '0);
    status_o.used_full = (used_q == UsedW'(MaxTables));
    status_o.used_zero = (used_q == '0);
    status_o.clr_last  = (clr_q[StateW-1:0] == StateW'(MaxStates - 1));
    status_o.ev_stop   = is_inf(ent_rd_q) || ((UsedW'(ev_i_q) + UsedW'(1)) == used_q);
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

/* rtl/core/slth_ctrl.sv */
// sequencer for adds, table claims with clearing, and evaluation
module slth_ctrl import slth_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_func_i,
  input  logic         in_last_i,
  output logic         in_ready_o,
  input  slth_status_t status_i,
  output slth_cmd_t    cmd_o
);

  slth_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i && status_i.abs_ok) begin
          cmd_o.capture = 1'b1;
          if (in_func_i == FuncAdd) begin
            state_d = StAddChk;
          end else begin
            cmd_o.qid_wr = 1'b1;
            if (in_last_i) begin
              cmd_o.ev_start = 1'b1;
              state_d = status_i.used_zero ? StDone : StEvQid;
            end
          end
        end
      end
      StAddChk: begin
        state_d = StIdle;
        if (status_i.hit) begin
          cmd_o.merge_wr = 1'b1;
        end else if (status_i.val_zero) begin
          state_d = StIdle;
        end else if (status_i.used_full) begin
          cmd_o.set_full = 1'b1;
        end else begin
          cmd_o.claim = 1'b1;
          state_d     = StClear;
        end
      end
      StClear: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StEvQid: begin
        cmd_o.ev_qid_rd = 1'b1;
        state_d         = StEvEnt;
      end
      StEvEnt: begin
        cmd_o.ev_ent_rd = 1'b1;
        state_d         = StEvAcc;
      end
      StEvAcc: begin
        cmd_o.ev_acc = 1'b1;
        state_d      = status_i.ev_stop ? StDone : StEvQid;
      end
      StDone: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

/* rtl/core/summed_lookup_table_heuristic_top.sv */
// top level of the summed lookup table heuristic
//
//  channel | dir | beat carries                               | result beats
//  in_i    | in  | func, abstraction, slot, value, last       | -
//  out_o   | out | estimate, store_full                       | one per final query beat
//
// one beat in flight at a time; a new beat is taken only while the sequencer idles
// add to a claimed table: store read, then merged write back
// add that claims a table: the claimed table is swept to zero, with the new value at its entry
// final query beat: per table in use a query id read, a store read and an accumulate step
// the result register holds its beat under a stall while the next beat is taken
// reset empties the table list and clears the full flag; no clearing pass after reset
module summed_lookup_table_heuristic_top import slth_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  slth_in_if.sink   in_i,
  slth_out_if.source out_o
);

  slth_item_t   item;
  slth_cmd_t    cmd;
  slth_status_t status;
  logic         ready;

  // pack the incoming beat
  always_comb begin
    item.func        = in_i.func;
    item.abstraction = in_i.abstraction;
    item.slot        = in_i.slot;
    item.value       = in_i.value;
    item.last        = in_i.last;
  end

  assign in_i.ready = ready;

  slth_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_func_i  (in_i.func),
    .in_last_i  (in_i.last),
    .in_ready_o (ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  slth_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_estimate_o   (out_o.estimate),
    .out_store_full_o (out_o.store_full)
  );

endmodule

/* rtl/core/slth_checker.sv */
// port level checks for the summed lookup table heuristic, bound to the top level
module slth_checker import slth_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   in_func_i,
  input logic                   in_last_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic signed [ValW-1:0] out_estimate_i,
  input logic                   out_store_full_i
);

  logic full_seen_q;

  // remember a full report once a beat carried it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_seen_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && out_store_full_i) begin
      full_seen_q <= 1'b1;
    end
  end

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_estimate_i)
                                    && $stable(out_store_full_i))
    else $error("result beat changed under stall");

  // the full flag is sticky across results
  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && full_seen_q |-> out_store_full_i)
    else $error("store full flag dropped");

  // estimate is never below zero unless it is minus infinity
  a_est_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !out_estimate_i[ValW-1] || (out_estimate_i == NegInf))
    else $error("estimate out of range");

  // evaluation blocks further beats
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_func_i == FuncQuery) && in_last_i |=> !in_ready_i)
    else $error("beat taken during evaluation");

endmodule

bind summed_lookup_table_heuristic_top slth_checker u_slth_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_func_i        (in_i.func),
  .in_last_i        (in_i.last),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_estimate_i   (out_o.estimate),
  .out_store_full_i (out_o.store_full)
);
